// ===== src/mth_pkg.sv =====
// Shared constants, types and codes for the spanning-tree tour block.
`timescale 1ns / 1ps
`default_nettype none
package mth_pkg;
  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int D2_W       = SQ_W + 1;
  localparam int KEY_W      = D2_W + 2 * IDX_W;
  localparam int SQ_STEPS   = 32 + FRAC_BITS;
  localparam int SQC_W      = $clog2(SQ_STEPS + 1);
  localparam int ROOT_W     = SQ_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int Q_W        = 64;
  localparam int LEN_W      = 31;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_INIT, OP_SCAN_START, OP_PICK, OP_FIND_A, OP_FIND_B,
    OP_UNION, OP_WALK_INIT, OP_POP, OP_SCANK, OP_LEN_START, OP_LEN_ADDR,
    OP_LEN_XY, OP_SQRT_LOAD, OP_SQRT, OP_LEN_ACC, OP_OUT_ADDR, OP_OUT_SHOW
  } op_t;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_CHECK, S_SCAN_START, S_SCAN, S_PICK, S_FIND_A, S_FIND_B,
    S_UNION, S_WALK_INIT, S_POP, S_SCANK, S_LEN_START, S_LEN_ADDR, S_LEN_XY,
    S_LEN_W1, S_SQRT_LOAD, S_SQRT, S_LEN_ACC, S_OUT_ADDR, S_OUT_SHOW
  } state_t;

  typedef struct packed {
    op_t  op;
    logic in_fire;
    logic out_fire;
  } cmd_t;

  typedef struct packed {
    logic more_edges;
    logic scan_busy;
    logic found;
    logic root_hit;
    logic walk_done;
    logic k_last;
    logic sq_last;
    logic len_last;
    logic out_last;
  } sts_t;
endpackage
`default_nettype wire

// ===== src/mth_ctrl.sv =====
// Sequencer for load, tree build, walk, length and result phases.
`timescale 1ns / 1ps
`default_nettype none
module mth_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last_point,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire mth_pkg::sts_t sts,
  output mth_pkg::cmd_t      cmd
);
  import mth_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.op       = OP_IDLE;
    cmd.in_fire  = 1'b0;
    cmd.out_fire = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready    = 1'b1;
        cmd.op      = OP_LOAD;
        cmd.in_fire = in_valid;
        if (in_valid && in_last_point) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_CHECK;
      end
      S_CHECK: state_nxt = sts.more_edges ? S_SCAN_START : S_WALK_INIT;
      S_SCAN_START: begin
        cmd.op    = OP_SCAN_START;
        state_nxt = S_SCAN;
      end
      S_SCAN: if (!sts.scan_busy) state_nxt = S_PICK;
      S_PICK: begin
        if (sts.found) begin
          cmd.op    = OP_PICK;
          state_nxt = S_FIND_A;
        end else begin
          state_nxt = S_WALK_INIT;
        end
      end
      S_FIND_A: begin
        cmd.op = OP_FIND_A;
        if (sts.root_hit) state_nxt = S_FIND_B;
      end
      S_FIND_B: begin
        cmd.op = OP_FIND_B;
        if (sts.root_hit) state_nxt = S_UNION;
      end
      S_UNION: begin
        cmd.op    = OP_UNION;
        state_nxt = S_CHECK;
      end
      S_WALK_INIT: begin
        cmd.op    = OP_WALK_INIT;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.walk_done) begin
          state_nxt = S_LEN_START;
        end else begin
          cmd.op    = OP_POP;
          state_nxt = S_SCANK;
        end
      end
      S_SCANK: begin
        cmd.op = OP_SCANK;
        if (sts.k_last) state_nxt = S_POP;
      end
      S_LEN_START: begin
        cmd.op    = OP_LEN_START;
        state_nxt = S_LEN_ADDR;
      end
      S_LEN_ADDR: begin
        cmd.op    = OP_LEN_ADDR;
        state_nxt = S_LEN_XY;
      end
      S_LEN_XY: begin
        cmd.op    = OP_LEN_XY;
        state_nxt = S_LEN_W1;
      end
      S_LEN_W1: state_nxt = S_SQRT_LOAD;
      S_SQRT_LOAD: begin
        cmd.op    = OP_SQRT_LOAD;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (sts.sq_last) state_nxt = S_LEN_ACC;
      end
      S_LEN_ACC: begin
        cmd.op    = OP_LEN_ACC;
        state_nxt = sts.len_last ? S_OUT_ADDR : S_LEN_ADDR;
      end
      S_OUT_ADDR: begin
        cmd.op    = OP_OUT_ADDR;
        state_nxt = S_OUT_SHOW;
      end
      S_OUT_SHOW: begin
        cmd.op       = OP_OUT_SHOW;
        out_valid    = 1'b1;
        cmd.out_fire = out_ready;
        if (out_ready) state_nxt = sts.out_last ? S_LOAD : S_OUT_ADDR;
      end
      default: state_nxt = S_LOAD;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/mth_dp.sv =====
// Point store, distance pipeline, union-find, tree walk and square-root datapath.
`timescale 1ns / 1ps
`default_nettype none
module mth_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mth_pkg::cmd_t cmd,
  output mth_pkg::sts_t      sts,
  input  wire logic [15:0]   in_x_coord,
  input  wire logic [15:0]   in_y_coord,
  output logic [mth_pkg::IDX_W-1:0] out_city_index,
  output logic [mth_pkg::LEN_W-1:0] out_tour_length,
  output logic               out_end_of_tour,
  output logic               out_points_dropped
);
  import mth_pkg::*;

  logic [COORD_BITS-1:0] xmem [MAX_POINTS];
  logic [COORD_BITS-1:0] ymem [MAX_POINTS];
  logic [IDX_W-1:0]      tmem [MAX_POINTS];
  logic [IDX_W-1:0]      root_r [MAX_POINTS];
  logic [MAX_POINTS-1:0] adj_r [MAX_POINTS];
  logic [IDX_W-1:0]      stk_r [MAX_POINTS];

  logic [CNT_W-1:0] pt_r, taken_r, sd_r, cnt_r, m_r, o_r;
  logic             ovf_r;
  logic [IDX_W-1:0] i_r, j_r, k_r, f_r, b_r, ra_r, cur_r;
  logic             scan_on_r, v1_r, v2_r, have_prev_r, found_r;
  logic [IDX_W-1:0] ti1_r, tj1_r, ti2_r, tj2_r;
  logic [KEY_W-1:0] prev_r, best_r;
  logic [MAX_POINTS-1:0] vis_r;

  logic [COORD_BITS-1:0] xa_r, xb_r, ya_r, yb_r;
  logic [SQ_W-1:0]       dxx_r, dyy_r;
  logic [IDX_W-1:0]      ta_r, tb_r;
  logic [IDX_W-1:0]      rd_a, rd_b, t_a, t_b;

  logic [ROOT_W-1:0] sroot_r;
  logic [REM_W-1:0]  srem_r;
  logic [Q_W-1:0]    q_r;
  logic [SQC_W-1:0]  sqc_r;
  logic [LEN_W-1:0]  sum_r;

  logic [COORD_BITS-1:0] dx, dy;
  logic [D2_W-1:0]       d2;
  logic [KEY_W-1:0]      key;
  logic                  cand, last_pair;
  logic [REM_W-1:0]      rem_s, trial;
  logic [ROOT_W:0]       acc;
  logic [IDX_W-1:0]      top_idx, pt_m1, pt_m2, cnt_m1;

  assign pt_m1  = IDX_W'(pt_r - 1'b1);
  assign pt_m2  = IDX_W'(pt_r - 2'd2);
  assign cnt_m1 = IDX_W'(cnt_r - 1'b1);
  assign top_idx = IDX_W'(sd_r - 1'b1);

  // memory read addresses
  always_comb begin
    rd_a = i_r;
    rd_b = j_r;
    if (cmd.op == OP_LEN_XY) begin
      rd_a = ta_r;
      rd_b = tb_r;
    end
    t_a = IDX_W'(o_r);
    t_b = '0;
    if (cmd.op == OP_LEN_ADDR) begin
      if (m_r == {1'b0, cnt_m1}) begin
        t_a = '0;
        t_b = cnt_m1;
      end else begin
        t_a = IDX_W'(m_r);
        t_b = IDX_W'(m_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_fire && pt_r < CNT_W'(MAX_POINTS)) begin
      xmem[IDX_W'(pt_r)] <= in_x_coord[COORD_BITS-1:0];
      ymem[IDX_W'(pt_r)] <= in_y_coord[COORD_BITS-1:0];
    end
    xa_r <= xmem[rd_a];
    xb_r <= xmem[rd_b];
    ya_r <= ymem[rd_a];
    yb_r <= ymem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_POP) tmem[IDX_W'(cnt_r)] <= stk_r[top_idx];
    ta_r <= tmem[t_a];
    tb_r <= tmem[t_b];
  end

  assign dx = (xa_r >= xb_r) ? xa_r - xb_r : xb_r - xa_r;
  assign dy = (ya_r >= yb_r) ? ya_r - yb_r : yb_r - ya_r;

  always_ff @(posedge clk) begin
    dxx_r <= dx * dx;
    dyy_r <= dy * dy;
  end

  assign d2   = {1'b0, dxx_r} + {1'b0, dyy_r};
  assign key  = {d2, ti2_r, tj2_r};
  assign cand = (!have_prev_r || key > prev_r) && (!found_r || key < best_r);
  assign last_pair = (i_r == pt_m2) && (j_r == pt_m1);

  assign rem_s = {srem_r[REM_W-3:0], q_r[Q_W-1:Q_W-2]};
  assign trial = {sroot_r, 2'b01};
  assign acc   = {1'b0, sroot_r} + (ROOT_W+1)'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r      <= '0;
      ovf_r     <= 1'b0;
      scan_on_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      found_r   <= 1'b0;
      have_prev_r <= 1'b0;
      taken_r   <= '0;
      sd_r      <= '0;
      cnt_r     <= '0;
      vis_r     <= '0;
      sum_r     <= '0;
      sqc_r     <= '0;
      m_r       <= '0;
      o_r       <= '0;
      k_r       <= '0;
      for (int n = 0; n < MAX_POINTS; n++) begin
        root_r[n] <= IDX_W'(n);
        adj_r[n]  <= '0;
      end
    end else begin
      v1_r  <= scan_on_r;
      ti1_r <= i_r;
      tj1_r <= j_r;
      v2_r  <= v1_r;
      ti2_r <= ti1_r;
      tj2_r <= tj1_r;
      if (v2_r && cand) begin
        best_r  <= key;
        found_r <= 1'b1;
      end
      if (scan_on_r) begin
        if (last_pair) begin
          scan_on_r <= 1'b0;
        end else if (j_r == pt_m1) begin
          i_r <= i_r + 1'b1;
          j_r <= IDX_W'(i_r + 2'd2);
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (cmd.in_fire) begin
        if (pt_r < CNT_W'(MAX_POINTS)) pt_r <= pt_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      case (cmd.op)
        OP_INIT: begin
          have_prev_r <= 1'b0;
          taken_r     <= '0;
          for (int n = 0; n < MAX_POINTS; n++) begin
            root_r[n] <= IDX_W'(n);
            adj_r[n]  <= '0;
          end
        end
        OP_SCAN_START: begin
          i_r       <= '0;
          j_r       <= IDX_W'(1);
          found_r   <= 1'b0;
          scan_on_r <= 1'b1;
        end
        OP_PICK: begin
          prev_r      <= best_r;
          have_prev_r <= 1'b1;
          f_r         <= best_r[2*IDX_W-1:IDX_W];
          b_r         <= best_r[IDX_W-1:0];
        end
        OP_FIND_A: begin
          if (root_r[f_r] == f_r) begin
            ra_r <= f_r;
            f_r  <= b_r;
          end else begin
            f_r <= root_r[f_r];
          end
        end
        OP_FIND_B: begin
          if (root_r[f_r] != f_r) f_r <= root_r[f_r];
        end
        OP_UNION: begin
          if (ra_r != f_r) begin
            root_r[ra_r] <= f_r;
            adj_r[prev_r[2*IDX_W-1:IDX_W]][prev_r[IDX_W-1:0]] <= 1'b1;
            adj_r[prev_r[IDX_W-1:0]][prev_r[2*IDX_W-1:IDX_W]] <= 1'b1;
            taken_r <= taken_r + 1'b1;
          end
        end
        OP_WALK_INIT: begin
          vis_r     <= MAX_POINTS'(1);
          stk_r[0]  <= '0;
          sd_r      <= CNT_W'(1);
          cnt_r     <= '0;
        end
        OP_POP: begin
          cur_r <= stk_r[top_idx];
          sd_r  <= sd_r - 1'b1;
          cnt_r <= cnt_r + 1'b1;
          k_r   <= '0;
        end
        OP_SCANK: begin
          if (adj_r[cur_r][k_r] && !vis_r[k_r] && sd_r < CNT_W'(MAX_POINTS)) begin
            vis_r[k_r]              <= 1'b1;
            stk_r[IDX_W'(sd_r)]     <= k_r;
            sd_r                    <= sd_r + 1'b1;
          end
          k_r <= k_r + 1'b1;
        end
        OP_LEN_START: begin
          sum_r <= '0;
          m_r   <= '0;
          o_r   <= '0;
        end
        OP_SQRT_LOAD: begin
          q_r     <= Q_W'(d2);
          sroot_r <= '0;
          srem_r  <= '0;
          sqc_r   <= SQC_W'(SQ_STEPS);
        end
        OP_SQRT: begin
          q_r   <= {q_r[Q_W-3:0], 2'b00};
          sqc_r <= sqc_r - 1'b1;
          if (rem_s >= trial) begin
            srem_r  <= rem_s - trial;
            sroot_r <= {sroot_r[ROOT_W-2:0], 1'b1};
          end else begin
            srem_r  <= rem_s;
            sroot_r <= {sroot_r[ROOT_W-2:0], 1'b0};
          end
        end
        OP_LEN_ACC: begin
          if (acc > (ROOT_W+1)'({LEN_W{1'b1}})) sum_r <= {LEN_W{1'b1}};
          else sum_r <= acc[LEN_W-1:0];
          m_r <= m_r + 1'b1;
        end
        OP_OUT_SHOW: begin
          if (cmd.out_fire) begin
            o_r <= o_r + 1'b1;
            if (o_r == {1'b0, cnt_m1}) begin
              pt_r  <= '0;
              ovf_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.more_edges = ((CNT_W+1)'(taken_r) + 1'b1) < (CNT_W+1)'(pt_r);
    sts.scan_busy  = scan_on_r || v1_r || v2_r;
    sts.found      = found_r;
    sts.root_hit   = (root_r[f_r] == f_r);
    sts.walk_done  = (sd_r == '0) || (cnt_r == CNT_W'(MAX_POINTS));
    sts.k_last     = ({1'b0, k_r} == CNT_W'(pt_m1));
    sts.sq_last    = (sqc_r == SQC_W'(1));
    sts.len_last   = (m_r == {1'b0, cnt_m1});
    sts.out_last   = (o_r == {1'b0, cnt_m1});
  end

  assign out_city_index     = ta_r;
  assign out_end_of_tour    = sts.out_last;
  assign out_tour_length    = sts.out_last ? sum_r : '0;
  assign out_points_dropped = ovf_r;
endmodule
`default_nettype wire

// ===== src/mst_tour_heuristic.sv =====
// Top level of the spanning-tree tour block.
//
//  channel  ports                                        role
//  in       in_valid/in_ready, in_x_coord, in_y_coord,   one point per request
//           in_last_point
//  out      out_valid/out_ready, out_city_index,         one tour stop per request
//           out_tour_length, out_end_of_tour, out_points_dropped
//
// Points load at one per cycle. The request flagged last starts the solve,
// during which in_ready is low: each candidate edge costs a full pair scan
// plus the union-find walks, the tree walk scans every point for each city
// it pops, and each tour leg runs through the bit-pair square-root unit.
// Results then leave one stop at a time, each addressed before it is shown.
// Reset is synchronous, active low; it empties the point set.
`timescale 1ns / 1ps
`default_nettype none
module mst_tour_heuristic (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_x_coord,
  input  wire logic [15:0] in_y_coord,
  input  wire logic        in_last_point,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_city_index,
  output logic [30:0]      out_tour_length,
  output logic             out_end_of_tour,
  output logic             out_points_dropped
);
  import mth_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mth_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  mth_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_x_coord         (in_x_coord),
    .in_y_coord         (in_y_coord),
    .out_city_index     (out_city_index),
    .out_tour_length    (out_tour_length),
    .out_end_of_tour    (out_end_of_tour),
    .out_points_dropped (out_points_dropped)
  );
endmodule
`default_nettype wire

// ===== dv/mst_tour_heuristic_tb.sv =====
// Self-checking testbench for mst_tour_heuristic: point sets in, tour stops checked.
`timescale 1ns / 1ps
module mst_tour_heuristic_tb;
  import mth_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic        hold;
  } point_req_t;

  typedef struct {
    logic [4:0]  city;
    logic [30:0] len;
    logic        eot;
    logic        dropped;
  } stop_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_x_coord;
  logic [15:0] in_y_coord;
  logic        in_last_point;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_city_index;
  logic [30:0] out_tour_length;
  logic        out_end_of_tour;
  logic        out_points_dropped;

  point_req_t pending_points[$];
  stop_t      expected_stops[$];

  logic [15:0] pt_x[MAX_POINTS];
  logic [15:0] pt_y[MAX_POINTS];
  int          pt_count;
  logic        pt_overflow;

  int  accepted;
  int  total_reqs;
  int  mismatches;
  int  cycles;
  int  phase;
  bit  in_took;
  bit  stim_done;

  mst_tour_heuristic uut (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [63:0] leg_dist_sq(int a, int b);
    logic [63:0] dx, dy;
    dx = (pt_x[a] >= pt_x[b]) ? 64'(pt_x[a] - pt_x[b]) : 64'(pt_x[b] - pt_x[a]);
    dy = (pt_y[a] >= pt_y[b]) ? 64'(pt_y[a] - pt_y[b]) : 64'(pt_y[b] - pt_y[a]);
    return dx * dx + dy * dy;
  endfunction

  // floor(sqrt(v) * 2^FRAC_BITS), bit pairs
  function automatic logic [63:0] leg_length(logic [63:0] v);
    logic [63:0] rem, root, pair, trial;
    rem = 0;
    root = 0;
    for (int p = 31 + FRAC_BITS; p >= 0; p--) begin
      pair = (p >= FRAC_BITS) ? ((v >> (2 * (p - FRAC_BITS))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic int root_of(int v, int parent[MAX_POINTS]);
    for (int k = 0; k < MAX_POINTS && parent[v] != v; k++) v = parent[v];
    return v;
  endfunction

  task automatic predict_tour();
    int          parent[MAX_POINTS];
    logic [31:0] adj[MAX_POINTS];
    int          stack[MAX_POINTS];
    int          order[MAX_POINTS];
    int          n, taken, count, depth, cur, ra, rb, a, b;
    logic [63:0] key, best, prev, sum;
    bit          found, have_prev;
    stop_t       s;
    n = pt_count;
    taken = 0;
    have_prev = 0;
    prev = 0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      parent[i] = i;
      adj[i] = '0;
    end
    while (taken + 1 < n) begin
      found = 0;
      best = 0;
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) begin
          key = (leg_dist_sq(i, j) << 12) | (64'(i) << 6) | 64'(j);
          if ((!have_prev || key > prev) && (!found || key < best)) begin
            best = key;
            found = 1;
          end
        end
      if (!found) break;
      prev = best;
      have_prev = 1;
      a = int'((best >> 6) & 64'd63);
      b = int'(best & 64'd63);
      ra = root_of(a, parent);
      rb = root_of(b, parent);
      if (ra != rb) begin
        parent[ra] = rb;
        adj[a][b] = 1'b1;
        adj[b][a] = 1'b1;
        taken++;
      end
    end
    stack[0] = 0;
    depth = 1;
    count = 0;
    begin
      logic [31:0] seen;
      seen = 32'd1;
      while (depth > 0 && count < MAX_POINTS) begin
        depth--;
        cur = stack[depth];
        order[count] = cur;
        count++;
        for (int k = 0; k < n; k++)
          if (adj[cur][k] && !seen[k] && depth < MAX_POINTS) begin
            seen[k] = 1'b1;
            stack[depth] = k;
            depth++;
          end
      end
    end
    sum = 0;
    for (int k = 0; k <= count - 1; k++) begin
      if (k + 1 < count) sum = sum + leg_length(leg_dist_sq(order[k], order[k + 1]));
      else sum = sum + leg_length(leg_dist_sq(order[0], order[count - 1]));
      if (sum > 64'h7FFF_FFFF) sum = 64'h7FFF_FFFF;
    end
    for (int k = 0; k < count; k++) begin
      s.city = order[k][4:0];
      s.len = (k + 1 == count) ? sum[30:0] : '0;
      s.eot = (k + 1 == count);
      s.dropped = pt_overflow;
      expected_stops.insert(expected_stops.size(), s);
    end
  endtask

  task automatic add_point(logic [15:0] x, logic [15:0] y, logic last, logic hold);
    point_req_t r;
    r.x = x;
    r.y = y;
    r.last = last;
    r.hold = hold;
    pending_points.insert(pending_points.size(), r);
  endtask

  // tight: coordinates drawn from a tiny range so distances tie
  task automatic add_set(int n, bit tight, bit hold);
    for (int i = 0; i < n; i++) begin
      if (tight) add_point(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                           i == n - 1, hold && i == 0);
      else add_point(16'($urandom), 16'($urandom), i == n - 1, hold && i == 0);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("mst_tour_heuristic regression: fail");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      in_took = 1;
      pending_points.pop_front();
      accepted++;
      if (pt_count < MAX_POINTS) begin
        pt_x[pt_count] = in_x_coord;
        pt_y[pt_count] = in_y_coord;
        pt_count++;
      end else begin
        pt_overflow = 1'b1;
      end
      if (in_last_point) begin
        predict_tour();
        pt_count = 0;
        pt_overflow = 1'b0;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_stops.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tour stop city=%0d", out_city_index);
      end else begin
        stop_t e;
        e = expected_stops.pop_front();
        if (out_city_index !== e.city || out_tour_length !== e.len ||
            out_end_of_tour !== e.eot || out_points_dropped !== e.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("stop mismatch: exp city=%0d len=%0d eot=%0b drop=%0b, got %0d %0d %0b %0b",
                     e.city, e.len, e.eot, e.dropped, out_city_index, out_tour_length,
                     out_end_of_tour, out_points_dropped);
        end
      end
    end
  end

  always @(negedge clk) begin
    phase = (total_reqs == 0) ? 0 : (accepted * 4) / total_reqs;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        in_took = 0;
        if (stim_done && pending_points.size() > 0 &&
            !(pending_points[0].hold && expected_stops.size() > 0) &&
            !((phase == 1 && $urandom_range(0, 99) < 73) ||
              (phase == 3 && $urandom_range(0, 99) < 23))) begin
          in_valid <= 1'b1;
          in_x_coord <= pending_points[0].x;
          in_y_coord <= pending_points[0].y;
          in_last_point <= pending_points[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !((phase == 2 && $urandom_range(0, 99) < 73) ||
                     (phase == 3 && $urandom_range(0, 99) < 23));
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    in_last_point = 1'b0;
    pt_count = 0;
    pt_overflow = 1'b0;
    accepted = 0;
    mismatches = 0;
    cycles = 0;
    in_took = 0;
    stim_done = 0;
    total_reqs = 0;

    add_point(16'd0, 16'd0, 1'b1, 1'b0);
    add_point(16'd0, 16'd0, 1'b0, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    add_point(16'd5, 16'd5, 1'b0, 1'b0);
    add_point(16'd5, 16'd5, 1'b0, 1'b0);
    add_point(16'd5, 16'd5, 1'b1, 1'b0);
    add_point(16'd0, 16'd0, 1'b0, 1'b0);
    add_point(16'hFFFF, 16'd0, 1'b0, 1'b0);
    add_point(16'd0, 16'hFFFF, 1'b0, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    add_set(6, 1, 0);
    add_set(34, 0, 0);
    add_set(33, 1, 0);

    while (pending_points.size() < 200) begin
      if ($urandom_range(0, 9) == 0) add_set($urandom_range(9, 32), $urandom_range(0, 3) == 0, 0);
      else add_set($urandom_range(1, 8), $urandom_range(0, 3) == 0,
                   pending_points.size() > 150 && pending_points.size() < 160);
    end
    add_set(32, 0, 1);
    total_reqs = pending_points.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    stim_done = 1;

    wait (pending_points.size() == 0 && expected_stops.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_stops.size() == 0) begin
      $display("mst_tour_heuristic regression: pass");
    end else begin
      $display("mst_tour_heuristic regression: fail");
    end
    $finish;
  end
endmodule

// ===== mst_tour_heuristic.f =====
src/mth_pkg.sv
src/mth_ctrl.sv
src/mth_dp.sv
src/mst_tour_heuristic.sv
dv/mst_tour_heuristic_tb.sv
